// ===== sv/bpp_pkg.sv =====
// ----------------------------------------------------------------------------
// Beat position projector package
// Shared widths, status codes and the sideband word carried down the pipeline.
// ----------------------------------------------------------------------------
package bpp_pkg;

  localparam int unsigned FracBits  = 32;
  localparam int unsigned BeatBits  = 64;
  localparam int unsigned ProdBits  = 72;
  localparam int unsigned IndexBits = 40;

  // Status codes of a result word.
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_ZERO_RATIO    = 3'd1;
  localparam logic [2:0] ST_EPOCH         = 3'd2;
  localparam logic [2:0] ST_BAD_ANCHOR    = 3'd3;
  localparam logic [2:0] ST_HORIZON       = 3'd4;
  localparam logic [2:0] ST_OVERFLOW      = 3'd5;
  localparam logic [2:0] ST_BEFORE_ORIGIN = 3'd6;

  // Per-word fields that ride alongside the beat division.
  typedef struct packed {
    logic [2:0]  status;
    logic        fwd;
    logic [63:0] base;
    logic [7:0]  num;
    logic [7:0]  den;
  } bpp_side_t;

endpackage

// ===== sv/bpp_front.sv =====
// ----------------------------------------------------------------------------
// Beat position projector front end
// Registers an input word, runs the early checks and forms the frame distance.
// ----------------------------------------------------------------------------
module bpp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [63:0]         anchor_epoch,
  input  logic [63:0]         query_epoch,
  input  logic [63:0]         reference_frame,
  input  logic [63:0]         beat_period,
  input  logic [63:0]         anchor_position_q32,
  input  logic [63:0]         target_frame,
  input  logic [7:0]          ratio_num,
  input  logic [7:0]          ratio_den,
  output logic                out_valid,
  output bpp_pkg::bpp_side_t  out_side,
  output logic [31:0]         out_dist,
  output logic [62:0]         out_period
);
  import bpp_pkg::*;

  logic        fwd;
  logic [63:0] frame_gap;
  logic [2:0]  status_next;

  // Direction and absolute distance between the two frames.
  always_comb begin
    fwd       = target_frame >= reference_frame;
    frame_gap = fwd ? target_frame - reference_frame : reference_frame - target_frame;
  end

  // The first failing check sets the status.
  always_comb begin
    if (ratio_num == 8'd0 || ratio_den == 8'd0) begin
      status_next = ST_ZERO_RATIO;
    end else if (anchor_epoch != query_epoch) begin
      status_next = ST_EPOCH;
    end else if (beat_period[63:32] == 32'd0 || beat_period[63]) begin
      status_next = ST_BAD_ANCHOR;
    end else if (frame_gap[63:32] != 32'd0) begin
      status_next = ST_HORIZON;
    end else begin
      status_next = ST_OK;
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_side.status <= status_next;
      out_side.fwd    <= fwd;
      out_side.base   <= anchor_position_q32;
      out_side.num    <= ratio_num;
      out_side.den    <= ratio_den;
      out_dist        <= frame_gap[31:0];
      out_period      <= beat_period[62:0];
    end
  end

endmodule

// ===== sv/bpp_beat_div.sv =====
// ----------------------------------------------------------------------------
// Beat position projector beat divider
// Pipelined restoring division of distance * 2^64 by the period, one
// quotient bit per stage, with a flag for a nonzero remainder.
// ----------------------------------------------------------------------------
module bpp_beat_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  bpp_pkg::bpp_side_t  in_side,
  input  logic [31:0]         in_dist,
  input  logic [62:0]         in_period,
  output logic                out_valid,
  output bpp_pkg::bpp_side_t  out_side,
  output logic [63:0]         out_beats,
  output logic                out_rem_left
);
  import bpp_pkg::*;

  localparam int unsigned Steps = BeatBits;

  logic [Steps:0] vld;
  bpp_side_t      side [Steps+1];
  logic [63:0]    rem  [Steps+1];
  logic [63:0]    quo  [Steps+1];
  logic [62:0]    per  [Steps+1];

  // The distance is below the period, so the integer steps give no quotient bits.
  assign vld[0]  = in_valid;
  assign side[0] = in_side;
  assign rem[0]  = {32'd0, in_dist};
  assign quo[0]  = 64'd0;
  assign per[0]  = in_period;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [63:0] shifted;
    logic [64:0] diff;
    logic        qbit;

    // One trial subtraction per stage.
    assign shifted = {rem[k][62:0], 1'b0};
    assign diff    = {1'b0, shifted} - {2'b00, per[k]};
    assign qbit    = !diff[64];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        side[k+1] <= side[k];
        rem[k+1]  <= qbit ? diff[63:0] : shifted;
        quo[k+1]  <= {quo[k][62:0], qbit};
        per[k+1]  <= per[k];
      end
    end
  end

  assign out_valid    = vld[Steps];
  assign out_side     = side[Steps];
  assign out_beats    = quo[Steps];
  assign out_rem_left = rem[Steps] != 64'd0;

endmodule

// ===== sv/bpp_scale.sv =====
// ----------------------------------------------------------------------------
// Beat position projector scaler
// Applies the beat count to the anchor position, multiplies by the ratio
// numerator and divides by the denominator eight bits per stage.
// ----------------------------------------------------------------------------
module bpp_scale (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  bpp_pkg::bpp_side_t  in_side,
  input  logic [63:0]         in_beats,
  input  logic                in_rem_left,
  output logic                out_valid,
  output logic [2:0]          status,
  output logic [39:0]         beat_number,
  output logic [31:0]         beat_phase
);
  import bpp_pkg::*;

  localparam int unsigned BitsPerStage = 8;
  localparam int unsigned DivStages    = ProdBits / BitsPerStage;

  logic [64:0] sum;
  logic [64:0] ceil_beats;
  logic [2:0]  a_status_next;
  logic [63:0] a_pos_next;

  logic        a_valid;
  logic [2:0]  a_status;
  logic [63:0] a_pos;
  logic [7:0]  a_num;
  logic [7:0]  a_den;

  logic        b_valid;
  logic [2:0]  b_status;
  logic [71:0] b_prod;
  logic [7:0]  b_den;

  logic [DivStages:0] dvld;
  logic [2:0]         dstat [DivStages+1];
  logic [7:0]         dden  [DivStages+1];
  logic [71:0]        dword [DivStages+1];
  logic [7:0]         drem  [DivStages+1];

  // Forward add with carry out, or backward subtract of the ceiling.
  always_comb begin
    sum           = {1'b0, in_side.base} + {1'b0, in_beats};
    ceil_beats    = {1'b0, in_beats} + {64'd0, in_rem_left};
    a_status_next = in_side.status;
    a_pos_next    = 64'd0;
    if (in_side.fwd) begin
      a_pos_next = sum[63:0];
      if (in_side.status == ST_OK && sum[64]) begin
        a_status_next = ST_OVERFLOW;
      end
    end else begin
      a_pos_next = in_side.base - ceil_beats[63:0];
      if (in_side.status == ST_OK && ceil_beats > {1'b0, in_side.base}) begin
        a_status_next = ST_BEFORE_ORIGIN;
      end
    end
  end

  // Position stage and product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
    end
    if (en) begin
      a_status <= a_status_next;
      a_pos    <= a_pos_next;
      a_num    <= in_side.num;
      a_den    <= in_side.den;
      b_status <= a_status;
      b_prod   <= {64'd0, a_num} * {8'd0, a_pos};
      b_den    <= a_den;
    end
  end

  assign dvld[0]  = b_valid;
  assign dstat[0] = b_status;
  assign dden[0]  = b_den;
  assign dword[0] = b_prod;
  assign drem[0]  = 8'd0;

  // Divide by the denominator; quotient bits shift in as dividend bits leave.
  for (genvar k = 0; k < DivStages; k++) begin : g_div
    logic [71:0] word_next;
    logic [7:0]  rem_next;

    always_comb begin
      logic [8:0]  t;
      logic [71:0] w;
      logic [7:0]  r;
      w = dword[k];
      r = drem[k];
      for (int i = 0; i < BitsPerStage; i++) begin
        t = {r, w[71]};
        w = {w[70:0], 1'b0};
        if (t >= {1'b0, dden[k]}) begin
          t    = t - {1'b0, dden[k]};
          w[0] = 1'b1;
        end
        r = t[7:0];
      end
      word_next = w;
      rem_next  = r;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvld[k+1] <= 1'b0;
      end else if (en) begin
        dvld[k+1] <= dvld[k];
      end
      if (en) begin
        dstat[k+1] <= dstat[k];
        dden[k+1]  <= dden[k];
        dword[k+1] <= word_next;
        drem[k+1]  <= rem_next;
      end
    end
  end

  // Output register; an error word carries zero fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dvld[DivStages];
    end
    if (en) begin
      status <= dstat[DivStages];
      if (dstat[DivStages] == ST_OK) begin
        beat_number <= dword[DivStages][71:32];
        beat_phase  <= dword[DivStages][31:0];
      end else begin
        beat_number <= 40'd0;
        beat_phase  <= 32'd0;
      end
    end
  end

endmodule

// ===== sv/beat_position_projector.sv =====
// ----------------------------------------------------------------------------
// Beat position projector
// Projects a tempo anchor to a media frame and scales it by a small ratio.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_ready) takes one query word carrying the
//   anchor, the query epoch, the media frame and the ratio. The output channel
//   (out_valid / out_ready) gives one result word per query: status, whole
//   beat number and 32-bit phase. Error words carry zero number and phase.
//   The word passes 77 register stages: one check stage, 64 stages of the
//   beat divider (one quotient bit per stage), an add stage, a multiply
//   stage, nine stages of the ratio divider (eight bits per stage) and the
//   output register. One word is accepted every cycle while the receiver
//   takes results.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_ready falls; nothing is dropped or repeated.
//   Synchronous reset clears all valid bits; no state is kept between words.
// ----------------------------------------------------------------------------
module beat_position_projector (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] anchor_epoch,
  input  logic [63:0] query_epoch,
  input  logic [63:0] reference_frame,
  input  logic [63:0] beat_period,
  input  logic [63:0] anchor_position_q32,
  input  logic [63:0] target_frame,
  input  logic [7:0]  ratio_num,
  input  logic [7:0]  ratio_den,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [39:0] beat_number,
  output logic [31:0] beat_phase
);
  import bpp_pkg::*;

  logic        en;
  logic        f_valid;
  bpp_side_t   f_side;
  logic [31:0] f_dist;
  logic [62:0] f_period;
  logic        d_valid;
  bpp_side_t   d_side;
  logic [63:0] d_beats;
  logic        d_rem_left;

  // The pipeline advances unless a result is waiting to be taken.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  bpp_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .en                  (en),
    .in_valid            (in_valid),
    .anchor_epoch        (anchor_epoch),
    .query_epoch         (query_epoch),
    .reference_frame     (reference_frame),
    .beat_period         (beat_period),
    .anchor_position_q32 (anchor_position_q32),
    .target_frame        (target_frame),
    .ratio_num           (ratio_num),
    .ratio_den           (ratio_den),
    .out_valid           (f_valid),
    .out_side            (f_side),
    .out_dist            (f_dist),
    .out_period          (f_period)
  );

  bpp_beat_div u_beat_div (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (f_valid),
    .in_side      (f_side),
    .in_dist      (f_dist),
    .in_period    (f_period),
    .out_valid    (d_valid),
    .out_side     (d_side),
    .out_beats    (d_beats),
    .out_rem_left (d_rem_left)
  );

  bpp_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (d_valid),
    .in_side     (d_side),
    .in_beats    (d_beats),
    .in_rem_left (d_rem_left),
    .out_valid   (out_valid),
    .status      (status),
    .beat_number (beat_number),
    .beat_phase  (beat_phase)
  );

endmodule

// ===== sv/bpp_checker.sv =====
// ----------------------------------------------------------------------------
// Beat position projector checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module bpp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [39:0] beat_number,
  input logic [31:0] beat_phase
);
  import bpp_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(beat_number)
      && $stable(beat_phase))
    else $error("result word changed while stalled");

  // Error words carry zero fields.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> beat_number == 40'd0 && beat_phase == 32'd0)
    else $error("error word with nonzero fields");

  // A stalled result blocks new input.
  a_stall_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word after reset");

endmodule

bind beat_position_projector bpp_checker u_bpp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .beat_number (beat_number),
  .beat_phase  (beat_phase)
);

// ===== bench/beat_position_projector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beat position projector testbench
// Drives query words through the valid/ready input channel, predicts every
// result word with an independent exact-arithmetic model and compares each
// result word field by field, under random idling and a long receiver stall.
// ----------------------------------------------------------------------------
module beat_position_projector_tb;
  import bpp_pkg::*;

  localparam int unsigned PipeLatency = 77;
  localparam int unsigned RandomWords = 1500;
  localparam int unsigned CycleLimit  = 200000;

  typedef struct {
    logic [63:0] a_epoch;
    logic [63:0] q_epoch;
    logic [63:0] ref_frame;
    logic [63:0] period;
    logic [63:0] base;
    logic [63:0] frame;
    logic [7:0]  num;
    logic [7:0]  den;
  } query_t;

  typedef struct {
    logic [2:0]  st;
    logic [39:0] idx;
    logic [31:0] ph;
  } result_t;

  typedef struct {
    query_t  q;
    bit      typed;
    result_t r;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] anchor_epoch = '0;
  logic [63:0] query_epoch = '0;
  logic [63:0] reference_frame = '0;
  logic [63:0] beat_period = '0;
  logic [63:0] anchor_position_q32 = '0;
  logic [63:0] target_frame = '0;
  logic [7:0]  ratio_num = '0;
  logic [7:0]  ratio_den = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [39:0] beat_number;
  logic [31:0] beat_phase;

  result_t expected_words[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;
  bit          hold_off = 1'b0;

  beat_position_projector DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Exact projection, worked in wide integers rather than bit-serial steps.
  function automatic result_t project_beat(query_t q);
    result_t     r;
    logic [63:0] gap;
    logic [127:0] beats_w;
    logic [63:0] beats;
    logic        fwd;
    logic        inexact;
    logic [64:0] pos;
    logic [127:0] scaled;
    r = '{ST_OK, '0, '0};
    if (q.num == 0 || q.den == 0) begin
      r.st = ST_ZERO_RATIO;
      return r;
    end
    if (q.a_epoch != q.q_epoch) begin
      r.st = ST_EPOCH;
      return r;
    end
    if (q.period < 64'h1_0000_0000 || q.period[63]) begin
      r.st = ST_BAD_ANCHOR;
      return r;
    end
    fwd = q.frame >= q.ref_frame;
    gap = fwd ? q.frame - q.ref_frame : q.ref_frame - q.frame;
    if (gap[63:32] != 0) begin
      r.st = ST_HORIZON;
      return r;
    end
    beats_w = ({64'd0, gap} << 64) / q.period;
    inexact = (({64'd0, gap} << 64) % q.period) != 0;
    beats   = beats_w[63:0];
    if (fwd) begin
      pos = {1'b0, q.base} + {1'b0, beats};
      if (pos[64]) begin
        r.st = ST_OVERFLOW;
        return r;
      end
    end else begin
      pos = {1'b0, beats} + inexact;
      if (pos > {1'b0, q.base}) begin
        r.st = ST_BEFORE_ORIGIN;
        return r;
      end
      pos = {1'b0, q.base} - pos;
    end
    // The Q32.32 product divided by the denominator is already the floor.
    scaled = ({63'd0, pos} * q.num) / q.den;
    r.idx  = scaled[71:32];
    r.ph   = scaled[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // Result checking at each accepted word.
  always @(posedge clk) begin
    result_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", status, 0);
      end else begin
        w = expected_words.pop_front();
        if (status !== w.st) report_mismatch("status", status, w.st);
        if (beat_number !== w.idx) report_mismatch("beat_number", beat_number, w.idx);
        if (beat_phase !== w.ph) report_mismatch("beat_phase", beat_phase, w.ph);
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off, none near the end.
  initial begin
    int unsigned n;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 5);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 8);
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly well-formed queries inside the horizon, with some noise.
  function automatic query_t random_query();
    query_t q;
    int unsigned k;
    q.a_epoch   = rand64();
    q.q_epoch   = ($urandom_range(0, 15) == 0) ? rand64() : q.a_epoch;
    k           = $urandom_range(0, 3);
    q.period    = (k == 0) ? {$urandom_range(1, 8), 32'd0} + {32'd0, $urandom()} :
                  (k == 1) ? rand64() >> 1 :
                  (k == 2) ? (rand64() >> 1) >> $urandom_range(0, 30) :
                  {32'd1, $urandom()};
    if ($urandom_range(0, 19) == 0) q.period = rand64();
    q.ref_frame = rand64();
    k           = $urandom_range(0, 4);
    q.frame     = (k == 0) ? rand64() :
                  (k == 1) ? q.ref_frame - {32'd0, $urandom()} :
                  q.ref_frame + {32'd0, $urandom() >> $urandom_range(0, 31)};
    k           = $urandom_range(0, 3);
    q.base      = (k == 0) ? rand64() : (k == 1) ? ~({32'd0, $urandom()} >> $urandom_range(0, 31)) :
                  {$urandom_range(0, 1000), $urandom()};
    q.num       = ($urandom_range(0, 31) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    q.den       = ($urandom_range(0, 31) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    return q;
  endfunction

  task automatic send_query(query_t q);
    result_t w;
    int unsigned n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 5);
      repeat (n) @(posedge clk);
    end
    in_valid            <= 1'b1;
    anchor_epoch        <= q.a_epoch;
    query_epoch         <= q.q_epoch;
    reference_frame     <= q.ref_frame;
    beat_period         <= q.period;
    anchor_position_q32 <= q.base;
    target_frame        <= q.frame;
    ratio_num           <= q.num;
    ratio_den           <= q.den;
    @(posedge clk iff in_ready);
    w = project_beat(q);
    expected_words.push_back(w);
  endtask

  // Stimulus: directed table, then random words.
  initial begin
    row_t   rows[$];
    query_t q;
    int unsigned i;
    localparam logic [63:0] One = 64'h1_0000_0000;
    rows.push_back('{'{1, 1, 5, One, 0, 5, 0, 1}, 1, '{ST_ZERO_RATIO, 0, 0}});
    rows.push_back('{'{1, 1, 5, One, 0, 5, 1, 0}, 1, '{ST_ZERO_RATIO, 0, 0}});
    rows.push_back('{'{1, 2, 5, One, 0, 5, 1, 1}, 1, '{ST_EPOCH, 0, 0}});
    rows.push_back('{'{0, 0, 5, One - 1, 0, 5, 1, 1}, 1, '{ST_BAD_ANCHOR, 0, 0}});
    rows.push_back('{'{0, 0, 5, 64'h8000_0000_0000_0000, 0, 5, 1, 1}, 1,
                     '{ST_BAD_ANCHOR, 0, 0}});
    rows.push_back('{'{0, 0, 0, One, 0, One, 1, 1}, 1, '{ST_HORIZON, 0, 0}});
    rows.push_back('{'{0, 0, One, One, 0, 0, 1, 1}, 1, '{ST_HORIZON, 0, 0}});
    rows.push_back('{'{0, 0, 0, One, '1, 1, 1, 1}, 1, '{ST_OVERFLOW, 0, 0}});
    rows.push_back('{'{0, 0, 1, One, 0, 0, 1, 1}, 1, '{ST_BEFORE_ORIGIN, 0, 0}});
    rows.push_back('{'{0, 0, 7, One, One * 3, 7, 1, 1}, 1, '{ST_OK, 3, 0}});
    rows.push_back('{'{'1, '1, 0, One, 0, 64'hFFFF_FFFF, 255, 255}, 0, '{ST_OK, 0, 0}});
    rows.push_back('{'{0, 0, '1, 64'h7FFF_FFFF_FFFF_FFFF, '1, 64'hFFFF_FFFF_0000_0001,
                       255, 1}, 0, '{ST_OK, 0, 0}});
    rows.push_back('{'{0, 0, 64'hFFFF_FFFF, One * 3, One, 0, 1, 255}, 0, '{ST_OK, 0, 0}});
    rows.push_back('{'{0, 0, 0, One * 3, 0, 2, 255, 7}, 0, '{ST_OK, 0, 0}});
    rows.push_back('{'{5, 5, 10, One + 1, One * 10, 3, 3, 2}, 0, '{ST_OK, 0, 0}});
    rows.push_back('{'{0, 0, 0, One, '1, 0, 255, 255}, 1,
                     '{ST_OK, 40'h00_FFFF_FFFF, '1}});
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[r]) begin
      send_query(rows[r].q);
      if (rows[r].typed) expected_words[$] = rows[r].r;
    end
    for (i = 0; i < RandomWords; i++) begin
      if (i == 300) hold_off = 1'b1;
      if (i == RandomWords - 200) calm = 1'b1;
      q = random_query();
      send_query(q);
    end
    in_valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (PipeLatency + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bpp_pkg.sv
sv/bpp_front.sv
sv/bpp_beat_div.sv
sv/bpp_scale.sv
sv/beat_position_projector.sv
sv/bpp_checker.sv
bench/beat_position_projector_tb.sv
